/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

/* rtl/emboss_pkg.sv */
// ----------------------------------------------------------------------------
// emboss_pkg
// Constants and payload types of the 3x3 emboss stream filter.
// ----------------------------------------------------------------------------
package emboss_pkg;

   localparam int PIXELS_PER_BEAT = 8;
   localparam int MAX_WIDTH       = 2048;

   localparam int PIXEL_W    = 8;
   localparam int BEAT_W     = 64;
   localparam int CFG_W      = 16;
   // lanes that actually carry pixels on the 64-bit bus
   localparam int BEAT_LANES = (PIXELS_PER_BEAT < BEAT_W / PIXEL_W) ?
                               PIXELS_PER_BEAT : BEAT_W / PIXEL_W;
   localparam int LINE_W     = PIXELS_PER_BEAT * PIXEL_W;
   localparam int WORD_W     = 2 * LINE_W;
   localparam int LINE_BEATS = MAX_WIDTH / PIXELS_PER_BEAT;
   localparam int ADDR_W     = $clog2(LINE_BEATS);
   localparam int EFF_W      = $clog2(MAX_WIDTH + 1);
   // positive and negative halves of the kernel sum, each below 2048
   localparam int ACC_W      = 11;

   localparam logic [CFG_W-1:0]   RESET_LINE_WIDTH = CFG_W'(2048);
   localparam logic [PIXEL_W-1:0] PIX_MAX          = 8'hFF;

   typedef struct packed {
      logic [BEAT_W-1:0] in_pixels;
      logic              in_last;
   } req_payload_type;

   typedef struct packed {
      logic [BEAT_W-1:0] out_pixels;
      logic              out_last;
      logic              width_error;
   } rsp_payload_type;

endpackage

/* rtl/emboss_ram.sv */
// ----------------------------------------------------------------------------
// emboss_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module emboss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/emboss_3x3_stream_filter_core.sv */
// ----------------------------------------------------------------------------
// emboss_3x3_stream_filter_core
// Streaming 3x3 emboss filter over packed 8-pixel beats with a line store.
// ----------------------------------------------------------------------------
// Takes one beat of eight 8-bit pixels per cycle while the result side is
// ready and returns one embossed beat per input beat, in order, through the
// compute stage and the result register. The rate of one beat per cycle is
// set by the line store: one read-modify-write of a 128-bit word (line
// above and line two above for the beat's eight columns) per beat, read at
// acceptance and written back when the beat leaves the compute stage. The
// store holds 256 words, cleared at reset through one valid flag per word,
// so the block is ready straight out of reset with no clearing pass. Columns
// before the start of a line read as zero. A line width above 2048 runs as
// 2048 and sets width_error on every result. Write the width register through
// the csr_ port only while the stream is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module emboss_3x3_stream_filter_core
   import emboss_pkg::*;
(
   input  logic            clock,
   input  logic            reset,

   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,

   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,

   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   // ---------------------------------------------------------------- config
   logic [CFG_W-1:0] line_width_ff;
   logic [EFF_W-1:0] eff_width;
   logic             width_err;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= RESET_LINE_WIDTH;
      end else if (csr_valid && csr_ready) begin
         line_width_ff <= csr_data;
      end
   end

   // clamp the width to the store size and flag the overrun
   assign width_err = line_width_ff > CFG_W'(MAX_WIDTH);
   assign eff_width = width_err ? EFF_W'(MAX_WIDTH) : line_width_ff[EFF_W-1:0];

   // ------------------------------------------------------------ handshake
   logic accept;
   logic s1_valid_ff;
   logic s1_fire;
   logic rsp_valid_ff;

   // the compute stage drains whenever the result register is free or emptying
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign accept    = req_valid && req_ready;

   // --------------------------------------------------------- column count
   // The column is always a multiple of the beat size, so count beats;
   // the beat index doubles as the line store address.
   logic [ADDR_W-1:0] beat_ff;
   logic [ADDR_W-1:0] beat_in;
   logic [ADDR_W:0]   beat_next;
   logic [EFF_W-1:0]  col_next;

   assign beat_next = {1'b0, beat_ff} + (ADDR_W + 1)'(1);
   assign col_next  = EFF_W'(beat_next) * EFF_W'(PIXELS_PER_BEAT);

   always_comb begin
      // wrap at the line width, rewind after the last beat of a frame
      if (col_next >= eff_width || req_data.in_last) begin
         beat_in = '0;
      end else begin
         beat_in = beat_next[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else if (accept) begin
         beat_ff <= beat_in;
      end
   end

   // ----------------------------------------------------------- line store
   logic              ram_we;
   logic [WORD_W-1:0] ram_wr_data;
   logic [WORD_W-1:0] ram_rd_data;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              word_valid_ff [LINE_BEATS];

   assign ram_we = s1_fire;

   emboss_ram #(
      .WIDTH (WORD_W),
      .DEPTH (LINE_BEATS)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (beat_ff),
      .rd_data (ram_rd_data)
   );

   // a word never written since reset reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE_BEATS; i++) begin
            word_valid_ff[i] <= 1'b0;
         end
      end else if (ram_we) begin
         word_valid_ff[s1_addr_ff] <= 1'b1;
      end
   end

   // -------------------------------------------------------- compute stage
   logic [BEAT_W-1:0] s1_pixels_ff;
   logic              s1_last_ff;
   logic              s1_err_ff;
   logic              s1_first_ff;
   logic              fwd_hit_ff;
   logic [WORD_W-1:0] fwd_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Capture the stage's payload with the RAM read. When the beat ahead
   // writes the same word on this very edge the RAM returns stale data,
   // so hold a copy of the write for forwarding.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixels_ff <= req_data.in_pixels;
         s1_last_ff   <= req_data.in_last;
         s1_err_ff    <= width_err;
         s1_first_ff  <= (beat_ff == '0);
         s1_addr_ff   <= beat_ff;
         fwd_hit_ff   <= ram_we && (s1_addr_ff == beat_ff);
         fwd_word_ff  <= ram_wr_data;
      end
   end

   // three-row columns c-2 and c-1 left by the previous beat
   logic [PIXEL_W-1:0] trail_top_ff [2];
   logic [PIXEL_W-1:0] trail_mid_ff [2];
   logic [PIXEL_W-1:0] trail_cur_ff [2];

   logic [WORD_W-1:0]  old_word;
   logic [LINE_W-1:0]  old_mid;
   logic [LINE_W-1:0]  old_top;
   logic [LINE_W-1:0]  s1_line;

   // window columns: index 0 and 1 are c-2 and c-1 of lane 0
   logic [PIXEL_W-1:0] ext_top [PIXELS_PER_BEAT + 2];
   logic [PIXEL_W-1:0] ext_mid [PIXELS_PER_BEAT + 2];
   logic [PIXEL_W-1:0] ext_cur [PIXELS_PER_BEAT + 2];

   logic [ACC_W-1:0]   acc_pos [PIXELS_PER_BEAT];
   logic [ACC_W-1:0]   acc_neg [PIXELS_PER_BEAT];
   logic [ACC_W-1:0]   acc_dif [PIXELS_PER_BEAT];
   logic [PIXEL_W-1:0] lane_res [PIXELS_PER_BEAT];

   rsp_payload_type    rsp_in;

   always_comb begin
      if (fwd_hit_ff) begin
         old_word = fwd_word_ff;
      end else if (word_valid_ff[s1_addr_ff]) begin
         old_word = ram_rd_data;
      end else begin
         old_word = '0;
      end
      old_mid = old_word[LINE_W-1:0];
      old_top = old_word[WORD_W-1:LINE_W];

      // lanes past the bus width read as zero
      s1_line = '0;
      for (int k = 0; k < BEAT_LANES; k++) begin
         s1_line[k*PIXEL_W +: PIXEL_W] = s1_pixels_ff[k*PIXEL_W +: PIXEL_W];
      end

      // drop the trailing columns at the start of a line
      for (int j = 0; j < 2; j++) begin
         ext_top[j] = s1_first_ff ? '0 : trail_top_ff[j];
         ext_mid[j] = s1_first_ff ? '0 : trail_mid_ff[j];
         ext_cur[j] = s1_first_ff ? '0 : trail_cur_ff[j];
      end
      for (int k = 0; k < PIXELS_PER_BEAT; k++) begin
         ext_top[k+2] = old_top[k*PIXEL_W +: PIXEL_W];
         ext_mid[k+2] = old_mid[k*PIXEL_W +: PIXEL_W];
         ext_cur[k+2] = s1_line[k*PIXEL_W +: PIXEL_W];
      end

      // Kernel split into its positive and negative taps:
      //   + 2*cur(c) + cur(c-1) + mid(c) + mid(c-1)
      //   - 2*top(c-2) - top(c-1) - mid(c-2)
      for (int k = 0; k < PIXELS_PER_BEAT; k++) begin
         acc_pos[k] = (ACC_W'(ext_cur[k+2]) << 1) + ACC_W'(ext_cur[k+1])
                    + ACC_W'(ext_mid[k+2]) + ACC_W'(ext_mid[k+1]);
         acc_neg[k] = (ACC_W'(ext_top[k]) << 1) + ACC_W'(ext_top[k+1])
                    + ACC_W'(ext_mid[k]);
         acc_dif[k] = acc_pos[k] - acc_neg[k];
         if (acc_pos[k] <= acc_neg[k]) begin
            lane_res[k] = '0;
         end else if (acc_dif[k] > ACC_W'(PIX_MAX)) begin
            lane_res[k] = PIX_MAX;
         end else begin
            lane_res[k] = acc_dif[k][PIXEL_W-1:0];
         end
      end

      rsp_in.out_pixels = '0;
      for (int k = 0; k < BEAT_LANES; k++) begin
         rsp_in.out_pixels[k*PIXEL_W +: PIXEL_W] = lane_res[k];
      end
      rsp_in.out_last    = s1_last_ff;
      rsp_in.width_error = s1_err_ff;
   end

   // shift the line down one row: new one-up is this beat, two-up the old one-up
   assign ram_wr_data = {old_mid, s1_line};

   // advance the trailing columns to the last two lanes of this beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 2; j++) begin
            trail_top_ff[j] <= '0;
            trail_mid_ff[j] <= '0;
            trail_cur_ff[j] <= '0;
         end
      end else if (s1_fire) begin
         for (int j = 0; j < 2; j++) begin
            trail_top_ff[j] <= ext_top[PIXELS_PER_BEAT + j];
            trail_mid_ff[j] <= ext_mid[PIXELS_PER_BEAT + j];
            trail_cur_ff[j] <= ext_cur[PIXELS_PER_BEAT + j];
         end
      end
   end

   // ------------------------------------------------------ result register
   rsp_payload_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ----------------------------------------------------------- assertions
   `ASSERT_PROP(a_last_rewinds_column,
      accept && req_data.in_last |=> beat_ff == '0,
      "column did not return to zero after a last transaction")
   `ASSERT_PROP(a_same_word_forwarded,
      ram_we && accept && (s1_addr_ff == beat_ff) |=> fwd_hit_ff,
      "same-edge write to the word being read was not forwarded")
   `ASSERT_PROP(a_result_from_stage,
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff),
      "result appeared without a transaction in the compute stage")
   `ASSERT_NEVER(a_stage_not_overrun,
      s1_valid_ff && !s1_fire && accept,
      "compute stage overwritten while holding a transaction")

endmodule

/* test/emboss_3x3_stream_filter_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emboss_3x3_stream_filter_core_tb
// Self-checking bench for the streaming 3x3 emboss filter core.
// ----------------------------------------------------------------------------
// Drives pixel beats through the req_ channel and predicts every embossed
// beat with a cycle-free model of the line store, the column counter and the
// two trailing columns. Each rsp_ transaction is compared field by field with
// the oldest prediction. The line width is rewritten through csr_ between
// phases, only once the stream has drained. Directed beats cover the left
// border, both clamp limits, zero and oversized widths and columns past the
// width; random frames of whole lines follow, with gaps and stalls on both
// sides and one long receiver hold-off that backs the filter up.
// ----------------------------------------------------------------------------
module emboss_3x3_stream_filter_core_tb;
   import emboss_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 6;
   // results pass the compute stage and the result register; allow a margin on top
   localparam int SETTLE_CYCLES   = 8;
   localparam int IDLE_LIMIT      = 1000;
   localparam int HOLD_OFF_CYCLES = 200;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_payload_type  req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_payload_type  rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data  = '0;

   // prediction state: entries 0..MAX_WIDTH-1 hold the line above,
   // the next MAX_WIDTH entries the line two above
   logic [PIXEL_W-1:0] line_history [2*MAX_WIDTH];
   logic [15:0]        next_column = '0;
   logic [CFG_W-1:0]   model_width = RESET_LINE_WIDTH;
   // trailing columns c-1 and c-2, each indexed two-up, one-up, current
   int                 left1 [3]   = '{0, 0, 0};
   int                 left2 [3]   = '{0, 0, 0};

   rsp_payload_type    expected_beats [$];
   rsp_payload_type    want;

   int  fail_count     = 0;
   int  beats_sent     = 0;
   int  beats_checked  = 0;
   int  widths_written = 0;
   int  quiet_cycles   = 0;
   int  hold_request   = 0;
   bit  sender_gaps    = 1'b0;
   bit  receiver_stalls = 1'b0;

   emboss_3x3_stream_filter_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Work out the embossed beat for one accepted input beat and advance the
   // prediction state exactly as the filter does.
   function automatic rsp_payload_type predict_emboss(input logic [BEAT_W-1:0] pixels,
                                                      input logic last);
      rsp_payload_type beat;
      int eff, col, x, k, r, sum;
      int here [3];
      beat = '0;
      eff  = model_width;
      if (eff > MAX_WIDTH) begin
         eff = MAX_WIDTH;
         beat.width_error = 1'b1;
      end
      col = next_column;
      // left border: nothing to the left of column zero
      if (col == 0) begin
         for (r = 0; r < 3; r++) begin
            left1[r] = 0;
            left2[r] = 0;
         end
      end
      for (k = 0; k < PIXELS_PER_BEAT; k++) begin
         x = col + k;
         here[2] = (k < BEAT_LANES) ? pixels[PIXEL_W*k +: PIXEL_W] : 0;
         if (x < MAX_WIDTH) begin
            here[0] = line_history[MAX_WIDTH + x];
            here[1] = line_history[x];
            line_history[MAX_WIDTH + x] = line_history[x];
            line_history[x] = PIXEL_W'(here[2]);
         end else begin
            here[0] = 0;
            here[1] = 0;
         end
         sum = -2 * left2[0] - left1[0] - left2[1] + left1[1] + here[1]
               + left1[2] + 2 * here[2];
         for (r = 0; r < 3; r++) begin
            left2[r] = left1[r];
            left1[r] = here[r];
         end
         if (sum < 0)
            sum = 0;
         else if (sum > int'(PIX_MAX))
            sum = int'(PIX_MAX);
         if (k < BEAT_LANES)
            beat.out_pixels[PIXEL_W*k +: PIXEL_W] = PIXEL_W'(sum);
      end
      col += PIXELS_PER_BEAT;
      if (col >= eff || last)
         col = 0;
      next_column   = 16'(col);
      beat.out_last = last;
      return beat;
   endfunction

   // Mostly short pauses, now and then a long one.
   function automatic int idle_span();
      if ($urandom_range(0, 99) < 88)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [BEAT_W-1:0] random_pixels();
      logic [BEAT_W-1:0]  p;
      logic [PIXEL_W-1:0] base;
      int k;
      base = PIXEL_W'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
         0, 1: p = {$urandom, $urandom};
         2: begin
            // hard black and white edges drive both clamp limits
            for (k = 0; k < BEAT_LANES; k++)
               p[PIXEL_W*k +: PIXEL_W] = ($urandom_range(0, 1) != 0) ? PIX_MAX : '0;
         end
         default: begin
            // near-flat area
            for (k = 0; k < BEAT_LANES; k++)
               p[PIXEL_W*k +: PIXEL_W] = base + PIXEL_W'($urandom_range(0, 7));
         end
      endcase
      return p;
   endfunction

   // Scoreboard: predict on every accepted request, compare every accepted
   // result. Push before pop so a same-edge result would still find its match.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            model_width = csr_data;
         if (req_valid && req_ready) begin
            expected_beats.push_back(predict_emboss(req_data.in_pixels, req_data.in_last));
            beats_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: result beat with nothing expected: %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               beats_checked++;
               if (rsp_data.out_pixels !== want.out_pixels) begin
                  $display("%0t: out_pixels expected %h, got %h", $time,
                           want.out_pixels, rsp_data.out_pixels);
                  fail_count++;
               end
               if (rsp_data.out_last !== want.out_last) begin
                  $display("%0t: out_last expected %b, got %b", $time,
                           want.out_last, rsp_data.out_last);
                  fail_count++;
               end
               if (rsp_data.width_error !== want.width_error) begin
                  $display("%0t: width_error expected %b, got %b", $time,
                           want.width_error, rsp_data.width_error);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog: count cycles in which no transaction of any kind completes.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog, %0d cycles without a transaction", $time, IDLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side pacing: random stalls, plus the long hold-off on request.
   initial begin : rsp_pacing
      int   stall_left;
      logic ready_next;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            ready_next = 1'b0;
            stall_left--;
         end else if (receiver_stalls && $urandom_range(0, 99) < 25) begin
            ready_next = 1'b0;
            stall_left = idle_span() - 1;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   // Offer one beat and hold it until accepted. Start and end on a falling
   // edge; leave valid high so back-to-back beats need no reassertion.
   task automatic send_beat(input logic [BEAT_W-1:0] pixels, input logic last);
      req_payload_type beat;
      int gap;
      beat.in_pixels = pixels;
      beat.in_last   = last;
      gap = (sender_gaps && $urandom_range(0, 99) < 30) ? idle_span() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid, wait for every outstanding result, then let the pipe settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_line_width(input logic [CFG_W-1:0] width);
      wait_idle();
      csr_data  <= width;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      widths_written++;
   endtask

   // Reset width, every line but the final beat closed by last: left border,
   // stacking of rows in the line store and both clamp limits.
   task automatic test_border_and_clamp();
      send_beat('1, 1'b1);
      send_beat('0, 1'b1);
      send_beat('1, 1'b1);
      send_beat(64'hFF00_FF00_FF00_FF00, 1'b0);
      send_beat(64'h00FF_00FF_00FF_00FF, 1'b1);
      send_beat(64'h0102_0408_1020_4080, 1'b1);
      send_beat(64'h8040_2010_0804_0201, 1'b0);
      wait_idle();
   endtask

   // Zero width, widths above the maximum, a width that ends mid-beat so
   // columns past it are still stored, a one-pixel line and the maximum.
   task automatic test_width_corners();
      int widths [6] = '{0, 65535, MAX_WIDTH + 1, 13, 1, MAX_WIDTH};
      int counts [6] = '{3, 2, 1, 4, 2, 2};
      int p, n;
      for (p = 0; p < 6; p++) begin
         write_line_width(CFG_W'(widths[p]));
         for (n = 0; n < counts[p]; n++)
            send_beat(random_pixels(), 1'b0);
      end
      wait_idle();
   endtask

   // Hold the result side for a long stretch while beats keep coming, so the
   // filter fills up and has to stall its input.
   task automatic test_input_stall();
      int n;
      write_line_width(CFG_W'(24));
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      hold_request    = HOLD_OFF_CYCLES;
      for (n = 0; n < 40; n++)
         send_beat(random_pixels(), n == 39);
      wait_idle();
   endtask

   // Frames of whole lines with random content; a few frames are cut short
   // by an early last. One phase per width, idling chosen per phase.
   task automatic test_random_stream();
      int widths [10] = '{16, 40, 8, MAX_WIDTH, 0, 13, 64, MAX_WIDTH - 1, 65535, 24};
      int p, n, beats, per_line, lines_in_frame, line_idx, beat_idx;
      logic last;
      for (p = 0; p < 10; p++) begin
         sender_gaps     = (p != 0) && ($urandom_range(0, 3) != 0);
         receiver_stalls = (p != 0) && ($urandom_range(0, 3) != 0);
         write_line_width(CFG_W'(widths[p]));
         // one full maximum-width line and a bit, short phases otherwise
         beats    = (widths[p] == MAX_WIDTH) ? 270 : 95;
         per_line = ((widths[p] > MAX_WIDTH ? MAX_WIDTH : widths[p]) + PIXELS_PER_BEAT - 1)
                    / PIXELS_PER_BEAT;
         if (per_line == 0)
            per_line = 1;
         lines_in_frame = $urandom_range(1, 6);
         line_idx = 0;
         beat_idx = 0;
         for (n = 0; n < beats; n++) begin
            last = (beat_idx == per_line - 1) && (line_idx == lines_in_frame - 1);
            if ($urandom_range(0, 99) < 3)
               last = 1'b1;
            send_beat(random_pixels(), last);
            if (last) begin
               line_idx = 0;
               beat_idx = 0;
               lines_in_frame = $urandom_range(1, 6);
            end else if (beat_idx == per_line - 1) begin
               beat_idx = 0;
               line_idx++;
            end else begin
               beat_idx++;
            end
         end
      end
      wait_idle();
   endtask

   initial begin
      int i;
      for (i = 0; i < 2 * MAX_WIDTH; i++)
         line_history[i] = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_border_and_clamp();
      test_width_corners();
      test_input_stall();
      test_random_stream();
      wait_idle();

      $display("Checked %0d of %0d embossed beats over %0d line-width writes,",
               beats_checked, beats_sent, widths_written);
      $display("with a %0d-cycle result hold-off and random idling.", HOLD_OFF_CYCLES);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/emboss_pkg.sv
rtl/emboss_ram.sv
rtl/emboss_3x3_stream_filter_core.sv
test/emboss_3x3_stream_filter_core_tb.sv
